// File: hw/rtl/urd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the ultrasonic range display.
// No dependencies; imported by ultrasonic_range_display.
package urd_pkg;

   localparam int COUNT_WIDTH     = 16;
   localparam int CFG_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int DIST_WIDTH      = 14;
   localparam int SEG_WIDTH       = 8;
   localparam int DIGITS          = 4;
   localparam int POS_WIDTH       = 2;

   localparam logic [DIST_WIDTH-1:0]  MAX_CM    = DIST_WIDTH'(9999);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // distance = floor(count * 5 / 29) as multiply by a rounded-up reciprocal
   localparam int DIST_SHIFT      = COUNT_WIDTH + 5;
   localparam int DIST_MULT_WIDTH = COUNT_WIDTH + 3;
   localparam int DIST_PROD_WIDTH = COUNT_WIDTH + DIST_MULT_WIDTH;
   localparam int DIST_Q_WIDTH    = DIST_PROD_WIDTH - DIST_SHIFT;
   localparam logic [DIST_MULT_WIDTH-1:0] DIST_MULT =
      DIST_MULT_WIDTH'(((64'd5 << DIST_SHIFT) + 64'd28) / 64'd29);

   // decimal digit from the fraction of value / 10^(pos+1)
   localparam int DIGIT_SHIFT  = 27;
   localparam int RECIP_WIDTH  = 24;
   localparam int DIG_PROD_WIDTH = DIST_WIDTH + RECIP_WIDTH;
   localparam logic [RECIP_WIDTH-1:0] RECIP_TENS =
      RECIP_WIDTH'(((64'd1 << DIGIT_SHIFT) + 64'd9) / 64'd10);
   localparam logic [RECIP_WIDTH-1:0] RECIP_HUNDREDS =
      RECIP_WIDTH'(((64'd1 << DIGIT_SHIFT) + 64'd99) / 64'd100);
   localparam logic [RECIP_WIDTH-1:0] RECIP_THOUSANDS =
      RECIP_WIDTH'(((64'd1 << DIGIT_SHIFT) + 64'd999) / 64'd1000);
   localparam logic [RECIP_WIDTH-1:0] RECIP_TEN_THOUSANDS =
      RECIP_WIDTH'(((64'd1 << DIGIT_SHIFT) + 64'd9999) / 64'd10000);

   typedef enum logic [1:0] {
      PH_TRIG  = 2'd0,
      PH_WAIT  = 2'd1,
      PH_COUNT = 2'd2,
      PH_GAP   = 2'd3
   } phase_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TRIGGER_TICKS = 2'd0,
      CSR_GAP_TICKS     = 2'd1,
      CSR_DIGIT_TICKS   = 2'd2
   } csr_index_type;

   function automatic logic [RECIP_WIDTH-1:0] digit_recip(input logic [POS_WIDTH-1:0] pos);
      logic [RECIP_WIDTH-1:0] r;
      case (pos)
         2'd0:    r = RECIP_TENS;
         2'd1:    r = RECIP_HUNDREDS;
         2'd2:    r = RECIP_THOUSANDS;
         default: r = RECIP_TEN_THOUSANDS;
      endcase
      return r;
   endfunction

   function automatic logic [SEG_WIDTH-1:0] seg_code(input logic [3:0] digit);
      logic [SEG_WIDTH-1:0] s;
      case (digit)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   // a tick count of zero behaves as one
   function automatic logic [CFG_WIDTH-1:0] at_least_one(input logic [CFG_WIDTH-1:0] v);
      return (v == '0) ? CFG_WIDTH'(1) : v;
   endfunction

endpackage

// File: hw/rtl/ultrasonic_range_display.sv
`timescale 1ns / 1ps
// Ultrasonic ranging controller with four-digit seven-segment scan output.
// Depends on urd_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  req     | in        | req_valid / req_ready | req_echo
//  rsp     | out       | rsp_valid / rsp_ready | rsp_trigger, rsp_digit_select,
//          |           |                       | rsp_segments, rsp_distance_cm, rsp_new_distance
//  csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// One tick transfer is taken every cycle while req_ready is high; its result passes through
// the four registers of the pipe in order (distance multiply, saturate, digit multiply,
// segment lookup) before it is offered.
// Controller state updates on the cycle a tick is taken; the pipe carries the result.
// Synchronous reset clears controller state and valid bits; tick counts reset to 100.
// A stalled result holds the whole pipe; req_ready follows the output stage.
module ultrasonic_range_display
   import urd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_echo,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_trigger,
   output logic [DIGITS-1:0]          rsp_digit_select,
   output logic [SEG_WIDTH-1:0]       rsp_segments,
   output logic [DIST_WIDTH-1:0]      rsp_distance_cm,
   output logic                       rsp_new_distance,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata
);

   logic [CFG_WIDTH-1:0]   trigger_ticks_ff, gap_ticks_ff, digit_ticks_ff;
   phase_type              phase_ff, phase_in;
   logic [CFG_WIDTH-1:0]   phase_timer_ff, phase_timer_in;
   logic [COUNT_WIDTH-1:0] echo_count_ff, echo_count_in;
   logic [DIST_WIDTH-1:0]  shown_ff, shown_in;
   logic [POS_WIDTH-1:0]   scan_pos_ff, scan_pos_in;
   logic [CFG_WIDTH-1:0]   scan_timer_ff, scan_timer_in;

   logic advance, accept;
   logic trig, fresh;
   logic phase_done_trig, phase_done_gap, scan_done;

   logic                    s1_valid_ff, s1_trig_ff, s1_fresh_ff;
   logic [POS_WIDTH-1:0]    s1_pos_ff;
   logic [DIST_Q_WIDTH-1:0] s1_dist_q_ff;
   logic [DIST_PROD_WIDTH-1:0] dist_prod;

   logic                    s2_valid_ff, s2_trig_ff, s2_fresh_ff;
   logic [POS_WIDTH-1:0]    s2_pos_ff;
   logic [DIST_WIDTH-1:0]   s2_dist_ff, dist_sat;

   logic                    s3_valid_ff, s3_trig_ff, s3_fresh_ff;
   logic [POS_WIDTH-1:0]    s3_pos_ff;
   logic [DIST_WIDTH-1:0]   s3_dist_ff;
   logic [DIGIT_SHIFT-1:0]  s3_frac_ff;
   logic [DIG_PROD_WIDTH-1:0] dig_prod;
   logic [DIGIT_SHIFT+3:0]  frac_x10;
   logic [3:0]              digit;

   logic                    rsp_valid_ff, rsp_trigger_ff, rsp_new_distance_ff;
   logic [DIGITS-1:0]       rsp_digit_select_ff;
   logic [SEG_WIDTH-1:0]    rsp_segments_ff;
   logic [DIST_WIDTH-1:0]   rsp_distance_cm_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff <= CFG_WIDTH'(100);
         gap_ticks_ff     <= CFG_WIDTH'(100);
         digit_ticks_ff   <= CFG_WIDTH'(100);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TRIGGER_TICKS: trigger_ticks_ff <= csr_wdata;
            CSR_GAP_TICKS:     gap_ticks_ff     <= csr_wdata;
            CSR_DIGIT_TICKS:   digit_ticks_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign phase_done_trig = ({1'b0, phase_timer_ff} + 17'd1) >=
                            {1'b0, at_least_one(trigger_ticks_ff)};
   assign phase_done_gap  = ({1'b0, phase_timer_ff} + 17'd1) >=
                            {1'b0, at_least_one(gap_ticks_ff)};
   assign scan_done       = ({1'b0, scan_timer_ff} + 17'd1) >=
                            {1'b0, at_least_one(digit_ticks_ff)};

   // phase sequencer: next state
   always_comb begin
      phase_in       = phase_ff;
      phase_timer_in = phase_timer_ff;
      echo_count_in  = echo_count_ff;
      case (phase_ff)
         PH_TRIG: begin
            if (phase_done_trig) begin
               phase_in       = PH_WAIT;
               phase_timer_in = '0;
            end else begin
               phase_timer_in = phase_timer_ff + CFG_WIDTH'(1);
            end
         end
         PH_WAIT: begin
            if (req_echo) begin
               echo_count_in = COUNT_WIDTH'(1);
               phase_in      = PH_COUNT;
            end
         end
         PH_COUNT: begin
            if (req_echo) begin
               if (echo_count_ff != COUNT_MAX) begin
                  echo_count_in = echo_count_ff + COUNT_WIDTH'(1);
               end
            end else begin
               phase_in       = PH_GAP;
               phase_timer_in = '0;
            end
         end
         PH_GAP: begin
            if (phase_done_gap) begin
               phase_in       = PH_TRIG;
               phase_timer_in = '0;
               echo_count_in  = '0;
            end else begin
               phase_timer_in = phase_timer_ff + CFG_WIDTH'(1);
            end
         end
         default: begin
            phase_in = PH_TRIG;
         end
      endcase
   end

   // phase sequencer: outputs
   always_comb begin
      trig  = 1'b0;
      fresh = 1'b0;
      case (phase_ff)
         PH_TRIG:  trig  = 1'b1;
         PH_COUNT: fresh = !req_echo;
         default: ;
      endcase
   end

   always_comb begin
      if (scan_done) begin
         scan_timer_in = '0;
         scan_pos_in   = scan_pos_ff + POS_WIDTH'(1);
      end else begin
         scan_timer_in = scan_timer_ff + CFG_WIDTH'(1);
         scan_pos_in   = scan_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TRIG;
         phase_timer_ff <= '0;
         echo_count_ff  <= '0;
         scan_pos_ff    <= '0;
         scan_timer_ff  <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         phase_timer_ff <= phase_timer_in;
         echo_count_ff  <= echo_count_in;
         scan_pos_ff    <= scan_pos_in;
         scan_timer_ff  <= scan_timer_in;
      end
   end

   // stage 1: distance multiply
   assign dist_prod = DIST_PROD_WIDTH'(echo_count_ff) * DIST_PROD_WIDTH'(DIST_MULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_trig_ff   <= trig;
         s1_fresh_ff  <= fresh;
         s1_pos_ff    <= scan_pos_ff;
         s1_dist_q_ff <= dist_prod[DIST_PROD_WIDTH-1:DIST_SHIFT];
      end
   end

   // stage 2: saturate and latch the shown value
   assign dist_sat = (32'(s1_dist_q_ff) > 32'(MAX_CM)) ? MAX_CM : DIST_WIDTH'(s1_dist_q_ff);
   assign shown_in = (s1_valid_ff && s1_fresh_ff) ? dist_sat : shown_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_ff    <= '0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         shown_ff    <= shown_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_trig_ff  <= s1_trig_ff;
         s2_fresh_ff <= s1_fresh_ff;
         s2_pos_ff   <= s1_pos_ff;
         s2_dist_ff  <= shown_in;
      end
   end

   // stage 3: digit multiply, keep the fraction
   assign dig_prod = DIG_PROD_WIDTH'(s2_dist_ff) * DIG_PROD_WIDTH'(digit_recip(s2_pos_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_trig_ff  <= s2_trig_ff;
         s3_fresh_ff <= s2_fresh_ff;
         s3_pos_ff   <= s2_pos_ff;
         s3_dist_ff  <= s2_dist_ff;
         s3_frac_ff  <= dig_prod[DIGIT_SHIFT-1:0];
      end
   end

   // stage 4: digit, segment lookup, result register
   assign frac_x10 = ({4'd0, s3_frac_ff} << 3) + ({4'd0, s3_frac_ff} << 1);
   assign digit    = frac_x10[DIGIT_SHIFT+3:DIGIT_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_trigger_ff      <= s3_trig_ff;
         rsp_new_distance_ff <= s3_fresh_ff;
         rsp_distance_cm_ff  <= s3_dist_ff;
         rsp_digit_select_ff <= DIGITS'(1) << s3_pos_ff;
         rsp_segments_ff     <= seg_code(digit);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_trigger      = rsp_trigger_ff;
   assign rsp_new_distance = rsp_new_distance_ff;
   assign rsp_distance_cm  = rsp_distance_cm_ff;
   assign rsp_digit_select = rsp_digit_select_ff;
   assign rsp_segments     = rsp_segments_ff;

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COUNT |-> echo_count_ff != '0)
      else $error("echo count is zero while counting");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TRIG |-> echo_count_ff == '0)
      else $error("echo count not cleared during trigger");

   a_select_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_digit_select))
      else $error("digit select not one-hot");

   a_distance_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance_cm <= MAX_CM)
      else $error("distance above saturation limit");

   a_latch_not_trig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_distance |-> !rsp_trigger)
      else $error("distance latched during trigger");

endmodule
